[hw/rtl/emt_pkg.sv]
// ----------------------------------------------------------------------------
// Extent map table package
// Shared types, command and status codes, and fixed limits.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_DEFRAG = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [15:0] LEN_LIMIT      = 16'hFFFF;
  localparam logic [15:0] FLAG_UNWRITTEN = 16'h0001;
  localparam logic [17:0] TOTAL_MAX      = 18'h3FFFF;

  typedef struct packed {
    logic [31:0] lblk;
    logic [31:0] pblk;
    logic [15:0] len;
    logic [15:0] attr;
  } entry_t;

  // Everything the sequencer needs to know about one entry against the query.
  typedef struct packed {
    logic        below;      // entry starts before the query block
    logic        contains;   // query block lies inside the entry
    logic        hit;        // entry overlaps the query range
    logic        head_in;    // entry starts at or after the query block
    logic        tail_in;    // entry ends at or before the range end
    logic        prev_over;  // entry end runs past the query block
    logic        next_over;  // query range end runs past the entry start
    logic        mergeable;  // held entry and this one join into one
    logic [31:0] q_end;
    logic [31:0] cut_pblk;
    logic [15:0] cut_len;
    logic [31:0] skip_pblk;
    logic [15:0] keep;
    logic [15:0] tail_len;
    logic [31:0] map_pblk;
    logic [15:0] run;
    logic [15:0] merged_len;
  } eval_t;

endpackage

[hw/rtl/emt_eval.sv]
// ----------------------------------------------------------------------------
// Extent evaluation unit
// Compares one table entry with the query range and the held neighbor.
// ----------------------------------------------------------------------------
module emt_eval (
  input  emt_pkg::entry_t ent,
  input  emt_pkg::entry_t last,
  input  logic [31:0]     lb,
  input  logic [31:0]     bc,
  output emt_pkg::eval_t  ev
);
  import emt_pkg::*;

  logic [32:0] ent_end;
  logic [32:0] q_end;
  logic [32:0] cut;
  logic [32:0] tail;
  logic [31:0] off;
  logic [32:0] last_lend;
  logic [32:0] last_pend;
  logic [16:0] len_sum;

  assign ent_end   = {1'b0, ent.lblk} + {17'd0, ent.len};
  assign q_end     = {1'b0, lb} + {1'b0, bc};
  assign cut       = q_end - {1'b0, ent.lblk};
  assign tail      = ent_end - q_end;
  assign off       = lb - ent.lblk;
  assign last_lend = {1'b0, last.lblk} + {17'd0, last.len};
  assign last_pend = {1'b0, last.pblk} + {17'd0, last.len};
  assign len_sum   = {1'b0, last.len} + {1'b0, ent.len};

  always_comb begin
    ev.below      = ent.lblk < lb;
    ev.contains   = (ent.lblk <= lb) && ({1'b0, lb} < ent_end);
    ev.hit        = !((ent_end <= {1'b0, lb}) || ({1'b0, ent.lblk} >= q_end));
    ev.head_in    = ent.lblk >= lb;
    ev.tail_in    = ent_end <= q_end;
    ev.prev_over  = ent_end > {1'b0, lb};
    ev.next_over  = q_end > {1'b0, ent.lblk};
    ev.mergeable  = (last_lend == {1'b0, ent.lblk}) && (last_pend == {1'b0, ent.pblk}) &&
                    (last.attr == ent.attr) && (len_sum <= {1'b0, LEN_LIMIT});
    ev.q_end      = q_end[31:0];
    ev.cut_pblk   = ent.pblk + cut[31:0];
    ev.cut_len    = ent.len - cut[15:0];
    ev.skip_pblk  = ent.pblk + cut[31:0];
    ev.keep       = off[15:0];
    ev.tail_len   = tail[15:0];
    ev.map_pblk   = ent.pblk + off;
    ev.run        = ent.len - off[15:0];
    ev.merged_len = len_sum[15:0];
  end

endmodule

[hw/rtl/extent_map_table.sv]
// ----------------------------------------------------------------------------
// Extent map table
// Sorted table of extents with add, remove, lookup and defragment commands.
// ----------------------------------------------------------------------------
// Usage: a command is one transfer on the in_ channel; each command gives
// exactly one transfer on the out_ channel with the status and table totals.
// The cfg_ channel writes the capacity register; it is always ready. The user must
// write it only while no command is in flight; the block does not enforce this.
// One command is worked at a time. A single evaluation unit visits one table
// entry per cycle under a sequencer, so the work from the input transfer to
// out_valid grows with the entry count N. in_ready is high only between commands.
// A finished result is held in the output register; if the receiver stalls,
// the next command may be taken and worked, and it waits at its end until
// the held result is taken.
// Reset empties the table, clears the modified bit and sets capacity to four.
// ----------------------------------------------------------------------------
module extent_map_table #(
  parameter int TABLE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_logical_block,
  input  logic [31:0] in_physical_block,
  input  logic [31:0] in_block_count,
  input  logic [15:0] in_extent_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_mapped_block,
  output logic [15:0] out_run_remaining,
  output logic        out_is_unwritten,
  output logic [2:0]  out_entry_total,
  output logic [17:0] out_block_total,
  output logic        out_changed_flag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_max_entries
);
  import emt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = 16 + CW;
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PACK    = 4'd1;
  localparam logic [3:0] S_FULLCHK = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_CHKP    = 4'd4;
  localparam logic [3:0] S_CHKN    = 4'd5;
  localparam logic [3:0] S_SHIFT   = 4'd6;
  localparam logic [3:0] S_INS     = 4'd7;
  localparam logic [3:0] S_REM     = 4'd8;
  localparam logic [3:0] S_RSHIFT  = 4'd9;
  localparam logic [3:0] S_RINS    = 4'd10;
  localparam logic [3:0] S_LOOK    = 4'd11;
  localparam logic [3:0] S_SUM     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  entry_t tbl_r [TABLE_DEPTH];

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          mod_r, mod_nxt;
  logic [2:0]    max_r;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic          merge_en_r, merge_en_nxt;
  logic          ret_full_r, ret_full_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   lb_r, lb_nxt;
  logic [31:0]   pb_r, pb_nxt;
  logic [31:0]   bc_r, bc_nxt;
  logic [15:0]   fl_r, fl_nxt;
  entry_t        last_r, last_nxt;
  entry_t        tail_r, tail_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [31:0]   map_r, map_nxt;
  logic [15:0]   run_r, run_nxt;
  logic          unw_r, unw_nxt;
  logic [SW-1:0] sum_r, sum_nxt;

  logic          ov_r;
  logic [2:0]    o_st_r;
  logic [31:0]   o_map_r;
  logic [15:0]   o_run_r;
  logic          o_unw_r;
  logic [2:0]    o_tot_r;
  logic [17:0]   o_blk_r;
  logic          o_mod_r;
  logic          out_load;

  logic [CW-1:0] rd_sel;
  entry_t        rd_ent;
  logic          wr_en;
  logic [CW-1:0] wr_sel;
  entry_t        wr_ent;
  eval_t         ev;
  logic [31:0]   cap32;
  logic          at_cap;

  assign rd_ent = tbl_r[rd_sel[IW-1:0]];
  assign cap32  = (32'(max_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(max_r);
  assign at_cap = 32'(cnt_r) >= cap32;

  emt_eval u_eval (
    .ent  (rd_ent),
    .last (last_r),
    .lb   (lb_r),
    .bc   (bc_r),
    .ev   (ev)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mod_nxt      = mod_r;
    i_nxt        = i_r;
    w_nxt        = w_r;
    k_nxt        = k_r;
    lo_nxt       = lo_r;
    merge_en_nxt = merge_en_r;
    ret_full_nxt = ret_full_r;
    found_nxt    = found_r;
    lb_nxt       = lb_r;
    pb_nxt       = pb_r;
    bc_nxt       = bc_r;
    fl_nxt       = fl_r;
    last_nxt     = last_r;
    tail_nxt     = tail_r;
    st_nxt       = st_r;
    map_nxt      = map_r;
    run_nxt      = run_r;
    unw_nxt      = unw_r;
    sum_nxt      = sum_r;
    rd_sel       = i_r;
    wr_en        = 1'b0;
    wr_sel       = i_r;
    wr_ent       = rd_ent;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lb_nxt    = in_logical_block;
          pb_nxt    = in_physical_block;
          bc_nxt    = in_block_count;
          fl_nxt    = in_extent_flags;
          st_nxt    = ST_OK;
          map_nxt   = '0;
          run_nxt   = '0;
          unw_nxt   = 1'b0;
          sum_nxt   = '0;
          i_nxt     = '0;
          w_nxt     = '0;
          lo_nxt    = '0;
          found_nxt = 1'b0;
          unique case (in_command)
            CMD_ADD: begin
              if (in_block_count == 32'd0 || in_block_count >= {16'd0, LEN_LIMIT}) begin
                st_nxt    = ST_INVALID;
                state_nxt = S_SUM;
              end else if (at_cap) begin
                merge_en_nxt = 1'b1;
                ret_full_nxt = 1'b1;
                state_nxt    = S_PACK;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (in_block_count == 32'd0) begin
                st_nxt    = ST_INVALID;
                state_nxt = S_SUM;
              end else begin
                state_nxt = S_REM;
              end
            end
            CMD_LOOKUP: begin
              st_nxt    = ST_NOTFOUND;
              state_nxt = S_LOOK;
            end
            CMD_DEFRAG: begin
              merge_en_nxt = 1'b1;
              ret_full_nxt = 1'b0;
              state_nxt    = S_PACK;
            end
          endcase
        end
      end

      // Drops empty entries and, when enabled, folds each entry that joins onto the
      // last kept one into it. last_r mirrors the entry at w_r - 1.
      S_PACK: begin
        if (i_r < cnt_r) begin
          i_nxt = i_r + ONE;
          if (rd_ent.len != 16'd0) begin
            wr_en = 1'b1;
            if (merge_en_r && w_r != '0 && ev.mergeable) begin
              wr_sel       = w_r - ONE;
              wr_ent       = last_r;
              wr_ent.len   = ev.merged_len;
              last_nxt.len = ev.merged_len;
            end else begin
              wr_sel   = w_r;
              last_nxt = rd_ent;
              w_nxt    = w_r + ONE;
            end
          end
        end else begin
          cnt_nxt   = w_r;
          i_nxt     = '0;
          state_nxt = ret_full_r ? S_FULLCHK : S_SUM;
        end
      end

      S_FULLCHK: begin
        if (at_cap) begin
          st_nxt    = ST_FULL;
          state_nxt = S_SUM;
        end else begin
          lo_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end

      // The table is sorted, so counting the entries below the start gives
      // the insert position.
      S_SCAN: begin
        if (i_r < cnt_r) begin
          if (ev.below) lo_nxt = lo_r + ONE;
          i_nxt = i_r + ONE;
        end else begin
          state_nxt = S_CHKP;
        end
      end

      S_CHKP: begin
        rd_sel = lo_r - ONE;
        if (lo_r != '0 && ev.prev_over) begin
          st_nxt    = ST_OVERLAP;
          i_nxt     = '0;
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_CHKN;
        end
      end

      S_CHKN: begin
        rd_sel = lo_r;
        if (lo_r < cnt_r && ev.next_over) begin
          st_nxt    = ST_OVERLAP;
          i_nxt     = '0;
          state_nxt = S_SUM;
        end else begin
          k_nxt     = cnt_r;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (k_r > lo_r) begin
          rd_sel = k_r - ONE;
          wr_en  = 1'b1;
          wr_sel = k_r;
          k_nxt  = k_r - ONE;
        end else begin
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        wr_en        = 1'b1;
        wr_sel       = lo_r;
        wr_ent       = '{lblk: lb_r, pblk: pb_r, len: bc_r[15:0], attr: fl_r};
        cnt_nxt      = cnt_r + ONE;
        mod_nxt      = 1'b1;
        merge_en_nxt = 1'b1;
        ret_full_nxt = 1'b0;
        i_nxt        = '0;
        w_nxt        = '0;
        state_nxt    = S_PACK;
      end

      S_REM: begin
        if (i_r < cnt_r) begin
          i_nxt = i_r + ONE;
          if (ev.hit) begin
            found_nxt = 1'b1;
            wr_en     = 1'b1;
            priority if (ev.head_in && ev.tail_in) begin
              wr_ent.len = 16'd0;
            end else if (ev.tail_in) begin
              wr_ent.len = ev.keep;
            end else if (ev.head_in) begin
              wr_ent.lblk = ev.q_end;
              wr_ent.pblk = ev.cut_pblk;
              wr_ent.len  = ev.cut_len;
            end else if (at_cap) begin
              // Split on a full table: earlier trims stay as they are.
              wr_en     = 1'b0;
              st_nxt    = ST_FULL;
              i_nxt     = '0;
              state_nxt = S_SUM;
            end else begin
              wr_ent.len = ev.keep;
              tail_nxt   = '{lblk: ev.q_end, pblk: ev.skip_pblk, len: ev.tail_len,
                             attr: rd_ent.attr};
              i_nxt      = i_r;
              k_nxt      = cnt_r;
              state_nxt  = S_RSHIFT;
            end
          end
        end else if (!found_r) begin
          st_nxt    = ST_NOTFOUND;
          i_nxt     = '0;
          state_nxt = S_SUM;
        end else begin
          mod_nxt      = 1'b1;
          merge_en_nxt = 1'b0;
          ret_full_nxt = 1'b0;
          i_nxt        = '0;
          w_nxt        = '0;
          state_nxt    = S_PACK;
        end
      end

      S_RSHIFT: begin
        if (k_r > i_r + ONE) begin
          rd_sel = k_r - ONE;
          wr_en  = 1'b1;
          wr_sel = k_r;
          k_nxt  = k_r - ONE;
        end else begin
          state_nxt = S_RINS;
        end
      end

      S_RINS: begin
        wr_en     = 1'b1;
        wr_sel    = i_r + ONE;
        wr_ent    = tail_r;
        cnt_nxt   = cnt_r + ONE;
        i_nxt     = i_r + ONE;
        state_nxt = S_REM;
      end

      S_LOOK: begin
        if (i_r < cnt_r) begin
          if (ev.contains) begin
            st_nxt    = ST_OK;
            map_nxt   = ev.map_pblk;
            run_nxt   = ev.run;
            unw_nxt   = (rd_ent.attr & FLAG_UNWRITTEN) != 16'd0;
            i_nxt     = '0;
            state_nxt = S_SUM;
          end else begin
            i_nxt = i_r + ONE;
          end
        end else begin
          i_nxt     = '0;
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        if (i_r < cnt_r) begin
          sum_nxt = sum_r + SW'(rd_ent.len);
          i_nxt   = i_r + ONE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      mod_r      <= 1'b0;
      max_r      <= 3'd4;
      ov_r       <= 1'b0;
      merge_en_r <= 1'b0;
      ret_full_r <= 1'b0;
      found_r    <= 1'b0;
      i_r        <= '0;
      w_r        <= '0;
      k_r        <= '0;
      lo_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      mod_r      <= mod_nxt;
      merge_en_r <= merge_en_nxt;
      ret_full_r <= ret_full_nxt;
      found_r    <= found_nxt;
      i_r        <= i_nxt;
      w_r        <= w_nxt;
      k_r        <= k_nxt;
      lo_r       <= lo_nxt;
      if (cfg_valid) max_r <= cfg_max_entries;
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lb_r   <= lb_nxt;
    pb_r   <= pb_nxt;
    bc_r   <= bc_nxt;
    fl_r   <= fl_nxt;
    last_r <= last_nxt;
    tail_r <= tail_nxt;
    st_r   <= st_nxt;
    map_r  <= map_nxt;
    run_r  <= run_nxt;
    unw_r  <= unw_nxt;
    sum_r  <= sum_nxt;
    if (wr_en) tbl_r[wr_sel[IW-1:0]] <= wr_ent;
    if (out_load) begin
      o_st_r  <= st_r;
      o_map_r <= map_r;
      o_run_r <= run_r;
      o_unw_r <= unw_r;
      o_tot_r <= (32'(cnt_r) > 32'd7) ? 3'd7 : 3'(cnt_r);
      o_blk_r <= (32'(sum_r) > 32'(TOTAL_MAX)) ? TOTAL_MAX : 18'(sum_r);
      o_mod_r <= mod_r;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_status        = o_st_r;
  assign out_mapped_block  = o_map_r;
  assign out_run_remaining = o_run_r;
  assign out_is_unwritten  = o_unw_r;
  assign out_entry_total   = o_tot_r;
  assign out_block_total   = o_blk_r;
  assign out_changed_flag  = o_mod_r;

endmodule

[hw/rtl/emt_checker.sv]
// ----------------------------------------------------------------------------
// Extent map table checker
// Port-level properties of the command and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module emt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_mapped_block,
  input logic [15:0] out_run_remaining,
  input logic        out_is_unwritten,
  input logic [2:0]  out_entry_total,
  input logic [17:0] out_block_total
);
  import emt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_block_total))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_INVALID ||
    out_status == ST_FULL || out_status == ST_OVERLAP || out_status == ST_NOTFOUND))
    else $error("unknown status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
    out_mapped_block == 32'd0 && out_run_remaining == 16'd0 && !out_is_unwritten)
    else $error("lookup fields set on a failed command");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_total == 3'd0 |-> out_block_total == 18'd0)
    else $error("blocks counted in an empty table");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transfer");

endmodule

bind extent_map_table emt_checker u_emt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_mapped_block  (out_mapped_block),
  .out_run_remaining (out_run_remaining),
  .out_is_unwritten  (out_is_unwritten),
  .out_entry_total   (out_entry_total),
  .out_block_total   (out_block_total)
);

[test/extent_map_table_tb.sv]
// ----------------------------------------------------------------------------
// Extent map table testbench
// Drives add, remove, lookup and defragment commands through the valid/ready
// channels, predicts every result with an independent model of the sorted
// extent table, and compares each result field by field. The capacity
// register is swept through several settings, extremes included.
// ----------------------------------------------------------------------------
module extent_map_table_tb;
  import emt_pkg::*;

  localparam int DEPTH = 4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mapped;
    logic [15:0] run;
    logic        unwritten;
    logic [2:0]  entries;
    logic [17:0] blocks;
    logic        changed;
  } result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] lb;
    logic [31:0] pb;
    logic [31:0] cnt;
    logic [15:0] fl;
    logic        known;
    logic [2:0]  st;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_logical_block;
  logic [31:0] in_physical_block;
  logic [31:0] in_block_count;
  logic [15:0] in_extent_flags;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_mapped_block;
  logic [15:0] out_run_remaining;
  logic        out_is_unwritten;
  logic [2:0]  out_entry_total;
  logic [17:0] out_block_total;
  logic        out_changed_flag;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_max_entries;

  extent_map_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_logical_block(in_logical_block), .in_physical_block(in_physical_block),
    .in_block_count(in_block_count), .in_extent_flags(in_extent_flags),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_mapped_block(out_mapped_block), .out_run_remaining(out_run_remaining),
    .out_is_unwritten(out_is_unwritten), .out_entry_total(out_entry_total),
    .out_block_total(out_block_total), .out_changed_flag(out_changed_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_max_entries(cfg_max_entries)
  );

  // Shadow copy of the extent table.
  logic [31:0] ext_lg [0:DEPTH];
  logic [31:0] ext_ph [0:DEPTH];
  logic [15:0] ext_ln [0:DEPTH];
  logic [15:0] ext_at [0:DEPTH];
  int          ext_cnt;
  logic        ext_mod;
  logic [2:0]  cap_reg;

  result_t pending_results[$];
  int      error_count;
  int      sent_count;
  int      checked_count;
  int      status_seen [0:7];
  int      idle_max;
  bit      long_hold_req;

  // Last add sent, so that follow-on adds can chain onto it.
  logic [31:0] chain_lb, chain_pb;
  logic [15:0] chain_fl;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int capacity();
    return (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
  endfunction

  function automatic logic [32:0] ext_end(int k);
    return {1'b0, ext_lg[k]} + ext_ln[k];
  endfunction

  function automatic void move_entry(int dst, int src);
    ext_lg[dst] = ext_lg[src];
    ext_ph[dst] = ext_ph[src];
    ext_ln[dst] = ext_ln[src];
    ext_at[dst] = ext_at[src];
  endfunction

  function automatic void drop_empty();
    int w;
    w = 0;
    for (int r = 0; r < ext_cnt && r < DEPTH; r++) begin
      if (ext_ln[r] != 0) begin
        if (w != r) move_entry(w, r);
        w++;
      end
    end
    ext_cnt = w;
  endfunction

  function automatic bit joinable(int a, int b);
    if (ext_end(a) != {1'b0, ext_lg[b]}) return 0;
    if ({1'b0, ext_ph[a]} + ext_ln[a] != {1'b0, ext_ph[b]}) return 0;
    if (ext_at[a] != ext_at[b]) return 0;
    return ({1'b0, ext_ln[a]} + ext_ln[b]) <= 17'd65535;
  endfunction

  function automatic void join_neighbours();
    int w;
    w = 0;
    if (ext_cnt <= 1) return;
    drop_empty();
    for (int r = 0; r < ext_cnt && r < DEPTH; r++) begin
      if (w != 0 && joinable(w - 1, r)) begin
        ext_ln[w - 1] = ext_ln[w - 1] + ext_ln[r];
      end else begin
        if (w != r) move_entry(w, r);
        w++;
      end
    end
    ext_cnt = w;
  endfunction

  function automatic logic [2:0] add_extent(logic [31:0] lb, logic [31:0] pb,
                                             logic [31:0] len, logic [15:0] fl);
    int lo, hi, mid;
    if (len == 0 || len >= 32'd65535) return ST_INVALID;
    if (ext_cnt >= capacity()) begin
      drop_empty();
      join_neighbours();
      if (ext_cnt >= capacity()) return ST_FULL;
    end
    lo = 0;
    hi = ext_cnt;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (ext_lg[mid] < lb) lo = mid + 1;
      else hi = mid;
    end
    if (lo > 0 && ext_end(lo - 1) > {1'b0, lb}) return ST_OVERLAP;
    if (lo < ext_cnt && {1'b0, lb} + len > {1'b0, ext_lg[lo]}) return ST_OVERLAP;
    for (int k = ext_cnt; k > lo; k--) move_entry(k, k - 1);
    ext_lg[lo] = lb;
    ext_ph[lo] = pb;
    ext_ln[lo] = len[15:0];
    ext_at[lo] = fl;
    ext_cnt++;
    ext_mod = 1'b1;
    join_neighbours();
    return ST_OK;
  endfunction

  function automatic logic [2:0] remove_range(logic [31:0] lb, logic [31:0] len);
    logic [32:0] lo_b, hi_b, s, e;
    logic [32:0] cut, keep, skip;
    bit          hit_any;
    hit_any = 0;
    if (len == 0) return ST_INVALID;
    lo_b = {1'b0, lb};
    hi_b = lo_b + len;
    for (int i = 0; i < ext_cnt && i < DEPTH; i++) begin
      s = {1'b0, ext_lg[i]};
      e = ext_end(i);
      if (e <= lo_b || s >= hi_b) continue;
      hit_any = 1;
      if (s >= lo_b && e <= hi_b) begin
        ext_ln[i] = 16'd0;
      end else if (s < lo_b && e <= hi_b) begin
        ext_ln[i] = 16'(lo_b - s);
      end else if (s >= lo_b && e > hi_b) begin
        cut = hi_b - s;
        ext_lg[i] = hi_b[31:0];
        ext_ph[i] = ext_ph[i] + cut[31:0];
        ext_ln[i] = ext_ln[i] - cut[15:0];
      end else begin
        // The range sits strictly inside this extent: split it in two.
        keep = lo_b - s;
        skip = hi_b - s;
        if (ext_cnt >= capacity()) return ST_FULL;
        for (int k = ext_cnt; k > i + 1; k--) move_entry(k, k - 1);
        ext_lg[i + 1] = hi_b[31:0];
        ext_ph[i + 1] = ext_ph[i] + skip[31:0];
        ext_ln[i + 1] = 16'(e - hi_b);
        ext_at[i + 1] = ext_at[i];
        ext_ln[i] = keep[15:0];
        ext_cnt++;
      end
    end
    if (!hit_any) return ST_NOTFOUND;
    drop_empty();
    ext_mod = 1'b1;
    return ST_OK;
  endfunction

  function automatic result_t predict_command(logic [1:0] cmd, logic [31:0] lb,
                                              logic [31:0] pb, logic [31:0] cnt,
                                              logic [15:0] fl);
    result_t     r;
    int          lo, hi, mid;
    logic [31:0] off;
    logic [18:0] sum;
    r = '0;
    case (cmd)
      CMD_ADD: r.status = add_extent(lb, pb, cnt, fl);
      CMD_REMOVE: r.status = remove_range(lb, cnt);
      CMD_LOOKUP: begin
        r.status = ST_NOTFOUND;
        lo = 0;
        hi = ext_cnt;
        while (lo < hi && lo < DEPTH) begin
          mid = (lo + hi) / 2;
          if (lb < ext_lg[mid]) begin
            hi = mid;
          end else if ({1'b0, lb} >= ext_end(mid)) begin
            lo = mid + 1;
          end else begin
            off = lb - ext_lg[mid];
            r.mapped = ext_ph[mid] + off;
            r.run = ext_ln[mid] - off[15:0];
            r.unwritten = (ext_at[mid] & FLAG_UNWRITTEN) != 0;
            r.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        drop_empty();
        join_neighbours();
      end
    endcase
    sum = '0;
    for (int k = 0; k < ext_cnt && k < DEPTH; k++) sum += ext_ln[k];
    r.blocks = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[17:0];
    r.entries = (ext_cnt > 7) ? 3'd7 : 3'(ext_cnt);
    r.changed = ext_mod;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
             checked_count, field, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_status), 32'hFFFF_FFFF);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_mapped_block !== want.mapped)
          report_mismatch("mapped_block", out_mapped_block, want.mapped);
        if (out_run_remaining !== want.run)
          report_mismatch("run_remaining", 32'(out_run_remaining), 32'(want.run));
        if (out_is_unwritten !== want.unwritten)
          report_mismatch("is_unwritten", 32'(out_is_unwritten), 32'(want.unwritten));
        if (out_entry_total !== want.entries)
          report_mismatch("entry_total", 32'(out_entry_total), 32'(want.entries));
        if (out_block_total !== want.blocks)
          report_mismatch("block_total", 32'(out_block_total), 32'(want.blocks));
        if (out_changed_flag !== want.changed)
          report_mismatch("changed_flag", 32'(out_changed_flag), 32'(want.changed));
        status_seen[want.status]++;
      end
      checked_count++;
    end
  end

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    int d;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      d = $urandom_range(0, idle_max);
      if (long_hold_req) begin
        d = 120;
        long_hold_req = 0;
      end
      if (d > 0) begin
        out_ready <= 1'b0;
        repeat (d) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [31:0] lb, logic [31:0] pb,
                              logic [31:0] cnt, logic [15:0] fl, logic known,
                              logic [2:0] st);
    int      gap;
    result_t r;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_logical_block <= lb;
    in_physical_block <= pb;
    in_block_count <= cnt;
    in_extent_flags <= fl;
    do @(posedge clk); while (!in_ready);
    r = predict_command(cmd, lb, pb, cnt, fl);
    if (known) r.status = st;
    pending_results.push_back(r);
    sent_count++;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [2:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_max_entries <= v;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_command(logic [31:0] base);
    logic [1:0]  cmd;
    logic [31:0] lb, pb, cnt;
    logic [15:0] fl;
    int          pick;
    pick = $urandom_range(0, 99);
    cmd = (pick < 45) ? CMD_ADD : (pick < 70) ? CMD_REMOVE :
          (pick < 94) ? CMD_LOOKUP : CMD_DEFRAG;
    lb = ($urandom_range(0, 99) < 85) ? base + $urandom_range(0, 300) : $urandom;
    pb = $urandom;
    cnt = $urandom;
    fl = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1)) : 16'($urandom);
    if (cmd == CMD_ADD) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) cnt = $urandom_range(1, 40);
      else if (pick < 85) cnt = 65534;
      else if (pick < 88) cnt = $urandom_range(30000, 40000);
      else if (pick < 94) cnt = ($urandom_range(0, 1) != 0) ? 32'd65535 : 32'd0;
      // Chain onto the previous add so that merges actually happen.
      if ($urandom_range(0, 99) < 55) begin
        lb = chain_lb + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        pb = chain_pb;
        fl = chain_fl;
      end
      chain_lb = lb + cnt;
      chain_pb = pb + cnt;
      chain_fl = fl;
    end else if (cmd == CMD_REMOVE) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) cnt = $urandom_range(1, 50);
      else if (pick < 92) cnt = 0;
    end
    send_command(cmd, lb, pb, cnt, fl, 1'b0, ST_OK);
  endtask

  row_t directed_rows [22] = '{
    '{CMD_LOOKUP, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, ST_NOTFOUND},
    '{CMD_REMOVE, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, ST_INVALID},
    '{CMD_ADD, 32'd5, 32'd5, 32'd0, 16'd0, 1'b1, ST_INVALID},
    '{CMD_ADD, 32'd5, 32'd5, 32'd65535, 16'd0, 1'b1, ST_INVALID},
    '{CMD_ADD, 32'd5, 32'd5, 32'hFFFF_FFFF, 16'd0, 1'b1, ST_INVALID},
    '{CMD_REMOVE, 32'd0, 32'd0, 32'd10, 16'd0, 1'b1, ST_NOTFOUND},
    '{CMD_ADD, 32'd100, 32'd1000, 32'd10, 16'd1, 1'b1, ST_OK},
    '{CMD_ADD, 32'd110, 32'd1010, 32'd10, 16'd1, 1'b1, ST_OK},
    '{CMD_ADD, 32'd105, 32'd0, 32'd3, 16'd0, 1'b1, ST_OVERLAP},
    '{CMD_LOOKUP, 32'd115, 32'd0, 32'd0, 16'd0, 1'b0, ST_OK},
    '{CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65534, 16'hFFFF, 1'b1, ST_OK},
    '{CMD_ADD, 32'd0, 32'd0, 32'd1, 16'd0, 1'b1, ST_OK},
    '{CMD_ADD, 32'd50, 32'd7, 32'd5, 16'd2, 1'b1, ST_OK},
    '{CMD_ADD, 32'd60, 32'd9, 32'd5, 16'd2, 1'b1, ST_FULL},
    '{CMD_REMOVE, 32'd102, 32'd0, 32'd3, 16'd0, 1'b1, ST_FULL},
    '{CMD_DEFRAG, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, ST_OK},
    '{CMD_REMOVE, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 1'b1, ST_OK},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 1'b0, ST_OK},
    '{CMD_REMOVE, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 16'd0, 1'b1, ST_OK},
    '{CMD_ADD, 32'd200, 32'd5, 32'd65534, 16'd0, 1'b1, ST_OK},
    '{CMD_ADD, 32'd65734, 32'd65539, 32'd1, 16'd0, 1'b1, ST_OK},
    '{CMD_ADD, 32'd65735, 32'd65540, 32'd1, 16'd0, 1'b1, ST_OK}
  };

  initial begin
    logic [2:0]  cap_plan [7] = '{3'd7, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd4};
    logic [31:0] base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOOKUP;
    in_logical_block = '0;
    in_physical_block = '0;
    in_block_count = '0;
    in_extent_flags = '0;
    cfg_valid = 1'b0;
    cfg_max_entries = 3'd4;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    idle_max = 5;
    long_hold_req = 0;
    chain_lb = 0;
    chain_pb = 0;
    chain_fl = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    for (int i = 0; i <= DEPTH; i++) begin
      ext_lg[i] = '0;
      ext_ph[i] = '0;
      ext_ln[i] = '0;
      ext_at[i] = '0;
    end
    ext_cnt = 0;
    ext_mod = 1'b0;
    cap_reg = 3'd4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].lb, directed_rows[i].pb,
                   directed_rows[i].cnt, directed_rows[i].fl,
                   directed_rows[i].known, directed_rows[i].st);
    in_valid <= 1'b0;

    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      // Some phases run back to back with no idle cycles at all.
      idle_max = (p % 3 == 1) ? 0 : 5;
      case ($urandom_range(0, 3))
        0: base = 32'hFFFF_FE00;
        1: base = $urandom;
        default: base = 0;
      endcase
      chain_lb = base;
      if (p == 2) long_hold_req = 1;
      for (int n = 0; n < 135; n++) random_command(base);
      in_valid <= 1'b0;
    end

    drain();
    $display("Sent %0d commands over %0d capacity settings; %0d results checked.",
             sent_count, 8, checked_count);
    $display("Status mix: ok %0d, invalid %0d, full %0d, overlap %0d, not found %0d.",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL],
             status_seen[ST_OVERLAP], status_seen[ST_NOTFOUND]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/emt_pkg.sv
hw/rtl/emt_eval.sv
hw/rtl/extent_map_table.sv
hw/rtl/emt_checker.sv
test/extent_map_table_tb.sv
